[sv/oec_pkg.sv]
// shared types, constants and helpers for the obstacle escape controller
`default_nettype none

package oec_pkg;

    localparam int RANGE_W     = 10;
    localparam int MAX_RANGE   = 1023;
    localparam int RESET_RANGE = 100;
    localparam int NUM_DIRS    = 4;
    localparam int SPEED_W     = 7;
    localparam int WHEEL_W     = 8;
    localparam int MAX_SPEED   = 100;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_DRIVE_SPEED     = 2'd0;
    localparam cfg_index_t CFG_SAFE_DISTANCE   = 2'd1;
    localparam cfg_index_t CFG_ESCAPE_DISTANCE = 2'd2;

    typedef enum logic [2:0] {
        MOT_IDLE    = 3'd0,
        MOT_REVERSE = 3'd1,
        MOT_FORWARD = 3'd2,
        MOT_LEFT    = 3'd3,
        MOT_RIGHT   = 3'd4
    } motion_t;

    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_BACK  = 2'd1,
        SIDE_LEFT  = 2'd2,
        SIDE_RIGHT = 2'd3
    } dir_t;

    typedef struct packed {
        logic [SPEED_W-1:0] drive_speed;
        logic [RANGE_W-1:0] safe_distance;
        logic [RANGE_W-1:0] escape_distance;
    } cfg_t;

    typedef struct packed {
        logic signed [WHEEL_W-1:0] left_wheel;
        logic signed [WHEEL_W-1:0] right_wheel;
        motion_t                   motion;
        dir_t                      direction;
        logic [RANGE_W-1:0]        mean;
    } result_t;

    // bits needed for a full window sum
    function automatic int sum_width(input int window);
        return $clog2(window * MAX_RANGE + 1);
    endfunction

endpackage

`default_nettype wire

[sv/oec_lane.sv]
// one direction lane: sample window shift line and running window sum
`default_nettype none

module oec_lane
    import oec_pkg::*;
#(
    parameter int WINDOW = 3
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           shift_en,
    input  wire logic [RANGE_W-1:0]             sample,
    output logic      [sum_width(WINDOW)-1:0]   sum
);

    localparam int SUM_W = sum_width(WINDOW);

    logic [RANGE_W-1:0] hist_reg  [WINDOW];
    logic [RANGE_W-1:0] hist_next [WINDOW];
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;

    always_comb
    begin
        for (int j = 0; j < WINDOW - 1; j++)
        begin
            hist_next[j] = hist_reg[j + 1];
        end
        hist_next[WINDOW-1] = sample;
    end

    // oldest sample leaves, new one enters
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample) - SUM_W'(hist_reg[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                hist_reg[j] <= RANGE_W'(RESET_RANGE);
            end
            sum_reg <= SUM_W'(RESET_RANGE * WINDOW);
        end
        else if (shift_en)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                hist_reg[j] <= hist_next[j];
            end
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

[sv/oec_merge.sv]
// merge stage: nearest lane search, motion decision, wheel commands and mean
`default_nettype none

module oec_merge
    import oec_pkg::*;
#(
    parameter int WINDOW = 3
)
(
    input  wire logic [sum_width(WINDOW)-1:0] lane_sum [NUM_DIRS],
    input  wire cfg_t                         cfg,
    input  wire motion_t                      motion_cur,
    output result_t                           result
);

    localparam int SUM_W  = sum_width(WINDOW);
    localparam int SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int RECIP  = ((2 ** SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PROD_W = SUM_W + SHIFT + 1;

    logic [SUM_W-1:0]         sum_a;
    logic [SUM_W-1:0]         sum_b;
    logic [SUM_W-1:0]         best_sum;
    dir_t                     dir_a;
    dir_t                     dir_b;
    dir_t                     best_dir;
    logic [SUM_W-1:0]         safe_lim;
    logic [SUM_W-1:0]         escape_lim;
    motion_t                  motion_next;
    logic [SPEED_W-1:0]       speed;
    logic signed [WHEEL_W-1:0] pos_speed;
    logic signed [WHEEL_W-1:0] neg_speed;
    logic signed [WHEEL_W-1:0] left_w;
    logic signed [WHEEL_W-1:0] right_w;
    logic [PROD_W-1:0]        prod;

    // two-level minimum tree, earlier direction kept on ties
    always_comb
    begin
        if (lane_sum[SIDE_BACK] < lane_sum[SIDE_FRONT])
        begin
            sum_a = lane_sum[SIDE_BACK];
            dir_a = SIDE_BACK;
        end
        else
        begin
            sum_a = lane_sum[SIDE_FRONT];
            dir_a = SIDE_FRONT;
        end
        if (lane_sum[SIDE_RIGHT] < lane_sum[SIDE_LEFT])
        begin
            sum_b = lane_sum[SIDE_RIGHT];
            dir_b = SIDE_RIGHT;
        end
        else
        begin
            sum_b = lane_sum[SIDE_LEFT];
            dir_b = SIDE_LEFT;
        end
        if (sum_b < sum_a)
        begin
            best_sum = sum_b;
            best_dir = dir_b;
        end
        else
        begin
            best_sum = sum_a;
            best_dir = dir_a;
        end
    end

    assign safe_lim   = SUM_W'(cfg.safe_distance) * SUM_W'(WINDOW);
    assign escape_lim = SUM_W'(cfg.escape_distance) * SUM_W'(WINDOW);

    // next motion state
    always_comb
    begin
        motion_next = motion_cur;
        if (best_sum > safe_lim)
        begin
            motion_next = MOT_IDLE;
        end
        else if (best_sum < escape_lim)
        begin
            unique case (best_dir)
                SIDE_FRONT: motion_next = MOT_REVERSE;
                SIDE_BACK:  motion_next = MOT_FORWARD;
                SIDE_LEFT:  motion_next = MOT_LEFT;
                SIDE_RIGHT: motion_next = MOT_RIGHT;
                default:    motion_next = MOT_IDLE;
            endcase
        end
    end

    assign speed     = (cfg.drive_speed > SPEED_W'(MAX_SPEED)) ? SPEED_W'(MAX_SPEED)
                                                               : cfg.drive_speed;
    assign pos_speed = {1'b0, speed};
    assign neg_speed = -pos_speed;

    // wheel commands for the new state
    always_comb
    begin
        unique case (motion_next)
            MOT_REVERSE:
            begin
                left_w  = neg_speed;
                right_w = neg_speed;
            end
            MOT_FORWARD:
            begin
                left_w  = pos_speed;
                right_w = pos_speed;
            end
            MOT_LEFT:
            begin
                left_w  = pos_speed;
                right_w = neg_speed;
            end
            MOT_RIGHT:
            begin
                left_w  = neg_speed;
                right_w = pos_speed;
            end
            default:
            begin
                left_w  = '0;
                right_w = '0;
            end
        endcase
    end

    // exact divide by window via reciprocal multiply
    assign prod = PROD_W'(best_sum) * PROD_W'(RECIP);

    always_comb
    begin
        result.left_wheel  = left_w;
        result.right_wheel = right_w;
        result.motion      = motion_next;
        result.direction   = best_dir;
        result.mean        = RANGE_W'(prod >> SHIFT);
    end

endmodule

`default_nettype wire

[sv/obstacle_escape_controller_core.sv]
// top level of the obstacle escape controller: lanes, merge, motion and output registers
`default_nettype none

// Takes one set of four range samples (front, back, left, right) per cycle unless stalled,
// returning one result per set. Each direction has its own lane holding the last WINDOW
// samples and a running window sum; a merge stage picks the nearest direction, updates the
// motion state against the scaled safe and escape thresholds and forms the wheel commands
// and the truncated window mean. The lane registers take the samples at the input transfer
// and the output register takes the merged result when the item leaves the lane stage,
// which a stalled output can delay. Throughput is one item per cycle while the output is
// not stalled; a stalled output holds the lane stage and then the input.
// Configuration is written through cfg_write, cfg_index and cfg_data; indexes beyond the
// last register are ignored.
module obstacle_escape_controller_core
    import oec_pkg::*;
#(
    parameter int WINDOW = 3
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [RANGE_W-1:0]         range_front,
    input  wire logic [RANGE_W-1:0]         range_back,
    input  wire logic [RANGE_W-1:0]         range_left,
    input  wire logic [RANGE_W-1:0]         range_right,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [WHEEL_W-1:0]       left_wheel,
    output logic signed [WHEEL_W-1:0]       right_wheel,
    output logic [2:0]                      motion_state,
    output logic [1:0]                      nearest_direction,
    output logic [RANGE_W-1:0]              nearest_mean
);

    localparam int SUM_W = sum_width(WINDOW);

    cfg_t               cfg_reg;
    logic [RANGE_W-1:0] samples  [NUM_DIRS];
    logic [SUM_W-1:0]   lane_sum [NUM_DIRS];
    logic               in_xfer;
    logic               advance;
    logic               lane_valid_reg;
    logic               lane_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    motion_t            motion_reg;
    result_t            merged;
    result_t            result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_speed     <= SPEED_W'(80);
            cfg_reg.safe_distance   <= RANGE_W'(75);
            cfg_reg.escape_distance <= RANGE_W'(15);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DRIVE_SPEED:     cfg_reg.drive_speed     <= cfg_data[SPEED_W-1:0];
                CFG_SAFE_DISTANCE:   cfg_reg.safe_distance   <= cfg_data[RANGE_W-1:0];
                CFG_ESCAPE_DISTANCE: cfg_reg.escape_distance <= cfg_data[RANGE_W-1:0];
                default:             ;
            endcase
        end
    end

    assign advance         = lane_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready        = !lane_valid_reg || advance;
    assign in_xfer         = in_valid && in_ready;
    assign lane_valid_next = in_xfer || (lane_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && !out_ready);

    assign samples[SIDE_FRONT] = range_front;
    assign samples[SIDE_BACK]  = range_back;
    assign samples[SIDE_LEFT]  = range_left;
    assign samples[SIDE_RIGHT] = range_right;

    for (genvar d = 0; d < NUM_DIRS; d++)
    begin : g_lane
        oec_lane #(
            .WINDOW   (WINDOW)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (in_xfer),
            .sample   (samples[d]),
            .sum      (lane_sum[d])
        );
    end

    oec_merge #(
        .WINDOW     (WINDOW)
    ) u_merge (
        .lane_sum   (lane_sum),
        .cfg        (cfg_reg),
        .motion_cur (motion_reg),
        .result     (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            motion_reg     <= MOT_IDLE;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                motion_reg <= merged.motion;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= merged;
        end
    end

    assign out_valid         = out_valid_reg;
    assign left_wheel        = result_reg.left_wheel;
    assign right_wheel       = result_reg.right_wheel;
    assign motion_state      = result_reg.motion;
    assign nearest_direction = result_reg.direction;
    assign nearest_mean      = result_reg.mean;

`ifndef SYNTHESIS
    // a full lane stage behind a stalled output must block new transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        (lane_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while lane stage is blocked");

    // motion state only moves when an item leaves the lane stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(motion_reg))
        else $error("motion state changed without a transfer");

    // idle result carries stopped wheels, moves carry equal magnitudes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((motion_state == MOT_IDLE && left_wheel == 0 && right_wheel == 0)
                           || (motion_state != MOT_IDLE
                               && (left_wheel == right_wheel || left_wheel == -right_wheel))))
        else $error("wheel commands disagree with motion state");
`endif

endmodule

`default_nettype wire
